[sv/jsu_pkg.sv]
package jsu_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_W  = 17;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CP_W   = 12;

	localparam logic [CFG_W-1:0] CAP_MAX     = 17'h10000;
	localparam logic [CFG_W-1:0] CAP_RESET   = 17'd512;

	// raw characters with meaning in the string body
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
	localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
	localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
	localparam logic [BYTE_W-1:0] CH_U      = 8'h75;

	// decoded control bytes
	localparam logic [BYTE_W-1:0] CTL_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CTL_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CTL_HT = 8'h09;
	localparam logic [BYTE_W-1:0] CTL_BS = 8'h08;
	localparam logic [BYTE_W-1:0] CTL_FF = 8'h0C;

	// utf-8 framing
	localparam logic [BYTE_W-1:0] UTF_LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] UTF_LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] UTF_CONT  = 8'h80;
	localparam logic [15:0]       CP_2BYTE  = 16'h0080;
	localparam logic [15:0]       CP_3BYTE  = 16'h0800;

	localparam logic [1:0] DIGIT_LAST = 2'd3;

	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_ESC  = 3'b010,
		MODE_HEX  = 3'b100
	} jsu_mode_t;

	// all results caused by one input byte: data bytes first, then the end mark
	typedef struct packed {
		logic [1:0]              nbytes;
		logic [2:0][BYTE_W-1:0]  bytes;
		logic                    done;
		logic [LEN_W-1:0]        length;
	} jsu_bundle_t;

	// hex digit value, anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end
		return v;
	endfunction

endpackage

[sv/jsu_if.sv]
interface jsu_in_if import jsu_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              string_done;
	logic [LEN_W-1:0]  string_length;
	logic              last;

	modport source (output valid, output out_byte, output byte_valid, output string_done,
		output string_length, output last, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input string_done,
		input string_length, input last, output ready);
endinterface

interface jsu_cfg_if import jsu_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/jsu_decode.sv]
module jsu_decode
	import jsu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              in_ready,
	input  logic              can_take,
	input  logic              cfg_valid,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              push,
	output jsu_bundle_t       bundle
);

	jsu_mode_t         mode_q, mode_nxt;
	logic [1:0]        digits_q, digits_nxt;
	logic [CP_W-1:0]   cp_q, cp_nxt;
	logic [LEN_W-1:0]  wcnt_q, wcnt_nxt;
	logic [CFG_W-1:0]  buffer_size_q;
	logic [CFG_W-1:0]  cap;
	logic [CFG_W-1:0]  wcnt_ext;
	logic              room1, room2, room3;
	logic [15:0]       cp_full;
	logic [BYTE_W-1:0] esc_byte;
	logic              accept;

	assign in_ready = can_take;
	assign accept   = in_valid & can_take;

	// capacity clamp and room checks
	assign cap      = (buffer_size_q > CAP_MAX) ? CAP_MAX : buffer_size_q;
	assign wcnt_ext = {1'b0, wcnt_q};
	assign room1    = (wcnt_ext + 17'd1) < cap;
	assign room2    = (wcnt_ext + 17'd2) < cap;
	assign room3    = (wcnt_ext + 17'd3) < cap;
	assign cp_full  = {cp_q, hex_value(in_byte)};

	// simple escape mapping, unknown escapes pass through
	always_comb begin
		unique case (in_byte)
			CH_N:    esc_byte = CTL_LF;
			CH_R:    esc_byte = CTL_CR;
			CH_T:    esc_byte = CTL_HT;
			CH_B:    esc_byte = CTL_BS;
			CH_F:    esc_byte = CTL_FF;
			default: esc_byte = in_byte;
		endcase
	end

	// next state and result bundle
	always_comb begin
		mode_nxt   = mode_q;
		digits_nxt = digits_q;
		cp_nxt     = cp_q;
		wcnt_nxt   = wcnt_q;
		bundle     = '0;
		unique case (mode_q)
			MODE_ESC: begin
				if (in_byte == CH_NUL) begin
					// backslash kept literally, then the string ends
					if (room1) begin
						bundle.nbytes   = 2'd1;
						bundle.bytes[0] = CH_BSLASH;
						bundle.length   = wcnt_q + 16'd1;
					end else begin
						bundle.length = wcnt_q;
					end
					bundle.done = 1'b1;
					mode_nxt    = MODE_TEXT;
					digits_nxt  = '0;
					cp_nxt      = '0;
					wcnt_nxt    = '0;
				end else if (in_byte == CH_U) begin
					mode_nxt   = MODE_HEX;
					digits_nxt = '0;
					cp_nxt     = '0;
				end else begin
					mode_nxt = MODE_TEXT;
					if (room1) begin
						bundle.nbytes   = 2'd1;
						bundle.bytes[0] = esc_byte;
						wcnt_nxt        = wcnt_q + 16'd1;
					end
				end
			end
			MODE_HEX: begin
				if (in_byte == CH_NUL) begin
					// partial code point dropped
					bundle.done   = 1'b1;
					bundle.length = wcnt_q;
					mode_nxt      = MODE_TEXT;
					digits_nxt    = '0;
					cp_nxt        = '0;
					wcnt_nxt      = '0;
				end else if (digits_q == DIGIT_LAST) begin
					mode_nxt   = MODE_TEXT;
					digits_nxt = '0;
					cp_nxt     = '0;
					// utf-8 encode, whole sequence or nothing
					if (cp_full < CP_2BYTE) begin
						if (room1) begin
							bundle.nbytes   = 2'd1;
							bundle.bytes[0] = cp_full[7:0];
							wcnt_nxt        = wcnt_q + 16'd1;
						end
					end else if (cp_full < CP_3BYTE) begin
						if (room2) begin
							bundle.nbytes   = 2'd2;
							bundle.bytes[0] = UTF_LEAD2 | {3'b000, cp_full[10:6]};
							bundle.bytes[1] = UTF_CONT | {2'b00, cp_full[5:0]};
							wcnt_nxt        = wcnt_q + 16'd2;
						end
					end else begin
						if (room3) begin
							bundle.nbytes   = 2'd3;
							bundle.bytes[0] = UTF_LEAD3 | {4'b0000, cp_full[15:12]};
							bundle.bytes[1] = UTF_CONT | {2'b00, cp_full[11:6]};
							bundle.bytes[2] = UTF_CONT | {2'b00, cp_full[5:0]};
							wcnt_nxt        = wcnt_q + 16'd3;
						end
					end
				end else begin
					cp_nxt     = cp_full[CP_W-1:0];
					digits_nxt = digits_q + 2'd1;
				end
			end
			default: begin
				if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
					bundle.done   = 1'b1;
					bundle.length = wcnt_q;
					mode_nxt      = MODE_TEXT;
					digits_nxt    = '0;
					cp_nxt        = '0;
					wcnt_nxt      = '0;
				end else if (in_byte == CH_BSLASH) begin
					mode_nxt = MODE_ESC;
				end else begin
					mode_nxt = MODE_TEXT;
					if (room1) begin
						bundle.nbytes   = 2'd1;
						bundle.bytes[0] = in_byte;
						wcnt_nxt        = wcnt_q + 16'd1;
					end
				end
			end
		endcase
	end

	assign push = accept & ((bundle.nbytes != 2'd0) | bundle.done);

	// parser state, advanced on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TEXT;
			digits_q <= '0;
			cp_q     <= '0;
			wcnt_q   <= '0;
		end else if (accept) begin
			mode_q   <= mode_nxt;
			digits_q <= digits_nxt;
			cp_q     <= cp_nxt;
			wcnt_q   <= wcnt_nxt;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= CAP_RESET;
		end else if (cfg_valid) begin
			buffer_size_q <= cfg_data;
		end
	end

endmodule

[sv/jsu_serialize.sv]
module jsu_serialize
	import jsu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_bundle_t       bundle,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic              string_done,
	output logic [LEN_W-1:0]  string_length,
	output logic              last
);

	jsu_bundle_t bundle_s1;
	logic        valid_s1;
	logic [1:0]  idx_q;
	logic [1:0]  total;
	logic        is_byte;
	logic        fire;
	logic        pop_final;

	// results in the bundle: never more than three
	assign total   = bundle_s1.nbytes + {1'b0, bundle_s1.done};
	assign is_byte = idx_q < bundle_s1.nbytes;

	// current result
	always_comb begin
		unique case (idx_q)
			2'd0:    out_byte = is_byte ? bundle_s1.bytes[0] : '0;
			2'd1:    out_byte = is_byte ? bundle_s1.bytes[1] : '0;
			2'd2:    out_byte = is_byte ? bundle_s1.bytes[2] : '0;
			default: out_byte = '0;
		endcase
	end

	assign out_valid     = valid_s1;
	assign byte_valid    = is_byte;
	assign string_done   = ~is_byte & bundle_s1.done;
	assign string_length = string_done ? bundle_s1.length : '0;
	assign last          = idx_q == (total - 2'd1);

	assign fire      = valid_s1 & out_ready;
	assign pop_final = fire & last;
	assign can_take  = ~valid_s1 | pop_final;

	// bundle register and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (push) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (pop_final) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bundle_s1 <= bundle;
		end
	end

endmodule

[sv/json_string_unescape_unit.sv]
// JSON string body unescaper. Feed the bytes after the opening quote, one per transfer on
// in_ch; decoded bytes come out on out_ch, one result per transfer, the cycle after the input
// is taken. A NUL, or a quote outside an escape or \uXXXX sequence, ends the string with a
// result carrying string_length, and the next byte starts a new string. A byte that yields k
// results (a \uXXXX sequence encoding to two or three UTF-8 bytes, or a backslash followed by
// NUL) holds the input until all k are out, since the single output register hands out one
// result per cycle while out_ch.ready is high. last marks the final result of each input byte. The
// capacity register (cfg_ch) is always ready and should be written only while the block is idle.
module json_string_unescape_unit
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    in_ch,
	jsu_out_if.source out_ch,
	jsu_cfg_if.sink   cfg_ch
);

	logic        push;
	logic        can_take;
	jsu_bundle_t bundle;

	assign cfg_ch.ready = 1'b1;

	// parser and encoder
	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_byte   (in_ch.in_byte),
		.in_ready  (in_ch.ready),
		.can_take  (can_take),
		.cfg_valid (cfg_ch.valid),
		.cfg_data  (cfg_ch.data),
		.push      (push),
		.bundle    (bundle)
	);

	// output register, one result per transfer
	jsu_serialize u_serialize (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.bundle        (bundle),
		.can_take      (can_take),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_byte      (out_ch.out_byte),
		.byte_valid    (out_ch.byte_valid),
		.string_done   (out_ch.string_done),
		.string_length (out_ch.string_length),
		.last          (out_ch.last)
	);

`ifndef NO_ASSERTIONS
	// end mark is always the final result and carries no byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.string_done) |-> (out_ch.last && !out_ch.byte_valid))
		else $error("string end not last result");

	// a NUL always ends the string
	a_nul_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.in_byte == CH_NUL) |-> (push && bundle.done))
		else $error("NUL did not end the string");

	// stored bundles are never empty
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (bundle.nbytes != 2'd0 || bundle.done))
		else $error("empty bundle stored");
`endif

endmodule
